// ===== rtl/core/sfa_pkg.sv =====
`default_nettype none
package sfa_pkg;
  localparam int unsigned GranuleBytesDef      = 8;
  localparam int unsigned LargestClassBytesDef = 128;
  localparam int unsigned HeaderBytesDef       = 8;
  localparam int unsigned PoolBytesDef         = 65536;

  localparam int unsigned ReqTypeW   = 1;
  localparam int unsigned ReqSizeW   = 12;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned RefillW    = 6;
  localparam int unsigned RegionW    = 17;
  localparam logic [RefillW-1:0] RefillReset = 6'd20;

  localparam logic [ReqTypeW-1:0] ReqAlloc = 1'b0;
  localparam logic [ReqTypeW-1:0] ReqFree  = 1'b1;

  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StOom      = 2'd1;
  localparam logic [StatusW-1:0] StTooLarge = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POP_RD,
    S_POP_WAIT,
    S_CARVE,
    S_DIVIDE,
    S_LEFTOVER,
    S_BACKING,
    S_SCAN,
    S_SCAN_RD,
    S_SCAN_WAIT,
    S_LINK,
    S_TAG,
    S_FREE_RD,
    S_FREE_WAIT,
    S_FREE_PUSH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } sfa_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/sfa_req_if.sv =====
`default_nettype none
interface sfa_req_if import sfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ReqTypeW-1:0] req_type;
  logic [ReqSizeW-1:0] req_size;
  logic [AddrW-1:0]    block_addr;
  modport source (output valid, req_type, req_size, block_addr, input ready);
  modport sink (input valid, req_type, req_size, block_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sfa_rsp_if.sv =====
`default_nettype none
interface sfa_rsp_if import sfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   user_addr;
  modport source (output valid, status, user_addr, input ready);
  modport sink (input valid, status, user_addr, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sfa_ram.sv =====
`default_nettype none
module sfa_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 14
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/core/segregated_freelist_allocator.sv =====
// Segregated free-list pool allocator.
// req: one transaction per allocate (req_type 0, req_size user bytes) or
//   free (req_type 1, block_addr). rsp: exactly one transaction per request,
//   status plus user_addr (block + header, 0 on free or error).
// cfg_we_i/cfg_wdata_i write refill_blocks (reset 20); write only when idle.
// A list hit goes POP_RD, POP_WAIT, TAG to OUT and a free goes FREE_RD,
//   FREE_WAIT, FREE_PUSH to OUT, where rsp is valid; the next request is
//   taken only in IDLE, after rsp is delivered. An oversize or ignored
//   request answers in the cycle after it is taken. A miss carves a region:
//   a 17-step restoring divider (one quotient bit a cycle) when the region
//   is short, a class-head scan from the request class upward, then one
//   next-link write per refilled block. The link memory's single write
//   port makes the refill writes serial; one request is in flight.
// Class heads live in flops (16 entries, valid by 0 = empty). next_link and
//   size_tag are synchronous-read RAMs, undefined until written, no clear.
// Reset empties all lists and zeroes the carve and backing pointers.
// When rsp stalls, the result is held in the output register and req is
//   not taken until it is delivered.
`default_nettype none
module segregated_freelist_allocator import sfa_pkg::*; #(
  parameter int unsigned GranuleBytes      = GranuleBytesDef,
  parameter int unsigned LargestClassBytes = LargestClassBytesDef,
  parameter int unsigned HeaderBytes       = HeaderBytesDef,
  parameter int unsigned PoolBytes         = PoolBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RefillW-1:0] cfg_wdata_i,
  sfa_req_if.sink                 req,
  sfa_rsp_if.source               rsp
);
  localparam int unsigned NClass  = LargestClassBytes / GranuleBytes;
  localparam int unsigned NGran   = PoolBytes / GranuleBytes;
  localparam int unsigned GW      = $clog2(NGran);
  localparam int unsigned LW      = GW + 1;          // link: granule + 1
  localparam int unsigned CW      = $clog2(NClass);
  localparam int unsigned GShift  = $clog2(GranuleBytes);
  localparam int unsigned PoolCap = (PoolBytes < 65536) ? PoolBytes : 65536;
  localparam int unsigned HdrRnd  =
    ((HeaderBytes + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
  localparam int unsigned BackLim = PoolCap - HdrRnd;
  localparam int unsigned TW      = 11;              // tag: header-inclusive size, at most 128
  localparam int unsigned WW      = 24;              // carve arithmetic width

  localparam logic [WW-1:0] BackLimW = WW'(BackLim);
  localparam logic [WW-1:0] HdrW     = WW'(HeaderBytes);
  localparam logic [WW-1:0] GranM1   = WW'(GranuleBytes - 1);
  localparam logic [WW-1:0] LargestW = WW'(LargestClassBytes);

  state_e state_q, state_d;

  logic [RefillW-1:0] refill_q;
  logic [LW-1:0]      head_q [NClass];
  logic [RegionW-1:0] cs_q, cs_d, ce_q, ce_d, bn_q, bn_d, ht_q, ht_d;

  logic [ReqTypeW-1:0] type_q, type_d;
  logic [WW-1:0]       s_q, s_d;        // header-inclusive size
  logic [CW-1:0]       c_q, c_d;        // request class
  logic [CW-1:0]       sc_q, sc_d;      // scan class
  logic [WW-1:0]       bs_q, bs_d;
  logic [RefillW-1:0]  n_q, n_d;
  logic [1:0]          pass_q, pass_d;
  logic [WW-1:0]       blk_q, blk_d;
  logic [RefillW-1:0]  k_q, k_d;
  logic [RegionW-1:0]  rem_q, rem_d;    // divider remainder
  logic [RegionW-1:0]  quo_q, quo_d;
  logic [4:0]          dcnt_q, dcnt_d;
  logic [RegionW-1:0]  dvd_q, dvd_d;
  logic [GW-1:0]       g_q, g_d;
  logic [StatusW-1:0]  st_q, st_d;
  logic [AddrW-1:0]    ua_q, ua_d;

  logic          head_we;
  logic [CW-1:0] head_wi;
  logic [LW-1:0] head_wd;

  logic          lk_we;
  logic [GW-1:0] lk_wa, lk_ra;
  logic [LW-1:0] lk_wd, lk_rd;
  logic          tg_we;
  logic [GW-1:0] tg_wa, tg_ra;
  logic [TW-1:0] tg_wd, tg_rd;

  sfa_ram #(.Depth(NGran), .Width(LW)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_wa), .wdata_i(lk_wd),
    .raddr_i(lk_ra), .rdata_o(lk_rd));
  sfa_ram #(.Depth(NGran), .Width(TW)) u_tag (
    .clk_i, .we_i(tg_we), .waddr_i(tg_wa), .wdata_i(tg_wd),
    .raddr_i(tg_ra), .rdata_o(tg_rd));

  sfa_status_t stat;
  assign stat.busy      = (state_q != S_IDLE);
  assign stat.out_valid = (state_q == S_OUT);

  assign req.ready     = !stat.busy;
  assign rsp.valid     = stat.out_valid;
  assign rsp.status    = st_q;
  assign rsp.user_addr = ua_q;

  function automatic logic [CW-1:0] class_of(input logic [WW-1:0] b);
    logic [WW-1:0] c;
    c = (b + GranM1) >> GShift;
    c = (c == '0) ? '0 : c - 1'b1;
    return (c < WW'(NClass)) ? c[CW-1:0] : CW'(NClass - 1);
  endfunction

  // working values of the carve step
  logic [WW-1:0] left_w, total_w, get_w, rnd_w;
  assign left_w  = WW'(ce_q) - WW'(cs_q);
  assign total_w = bs_q * WW'(n_q);
  assign rnd_w   = ((WW'(ht_q >> 4)) + GranM1) >> GShift << GShift;
  assign get_w   = (total_w << 1) + rnd_w;

  logic [RegionW:0] dtrial;
  assign dtrial = {rem_q, dvd_q[RegionW-1]} - {1'b0, bs_q[RegionW-1:0]};

  logic [WW-1:0] sub_w;
  assign sub_w = WW'(req.block_addr) - HdrW;

  always_comb begin
    state_d = state_q;
    cs_d = cs_q; ce_d = ce_q; bn_d = bn_q; ht_d = ht_q;
    type_d = type_q; s_d = s_q; c_d = c_q; sc_d = sc_q; bs_d = bs_q;
    n_d = n_q; pass_d = pass_q; blk_d = blk_q; k_d = k_q;
    rem_d = rem_q; quo_d = quo_q; dcnt_d = dcnt_q; dvd_d = dvd_q;
    g_d = g_q; st_d = st_q; ua_d = ua_q;
    head_we = 1'b0; head_wi = c_q; head_wd = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = g_q;
    tg_we = 1'b0; tg_wa = blk_q[GShift +: GW]; tg_wd = s_q[TW-1:0];
    tg_ra = g_q;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          type_d = req.req_type;
          st_d = StOk; ua_d = '0;
          s_d = WW'(req.req_size) + HdrW;
          if (req.req_type == ReqAlloc) begin
            if (WW'(req.req_size) + HdrW > LargestW) begin
              st_d = StTooLarge;
              state_d = S_OUT;
            end else begin
              c_d = class_of(WW'(req.req_size) + HdrW);
              state_d = S_POP_RD;
            end
          end else if (WW'(req.block_addr) >= HdrW && sub_w < BackLimW) begin
            g_d = sub_w[GShift +: GW];
            state_d = S_FREE_RD;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_POP_RD: begin
        bs_d = (WW'(c_q) + 1'b1) << GShift;
        n_d = (refill_q == '0) ? RefillW'(1) : refill_q;
        pass_d = '0;
        if (head_q[c_q] == '0) begin
          state_d = S_CARVE;
        end else begin
          g_d = GW'(head_q[c_q] - 1'b1);
          lk_ra = GW'(head_q[c_q] - 1'b1);
          state_d = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        head_we = 1'b1; head_wi = c_q; head_wd = lk_rd;
        blk_d = WW'(g_q) << GShift;
        state_d = S_TAG;
      end
      S_CARVE: begin
        if (pass_q == 2'd3) begin
          st_d = StOom; state_d = S_OUT;
        end else if (left_w >= total_w) begin
          blk_d = WW'(cs_q);
          cs_d = RegionW'(WW'(cs_q) + total_w);
          k_d = RefillW'(1);
          state_d = S_LINK;
        end else if (left_w >= bs_q) begin
          rem_d = '0; quo_d = '0; dvd_d = left_w[RegionW-1:0];
          dcnt_d = 5'(RegionW);
          state_d = S_DIVIDE;
        end else begin
          state_d = S_LEFTOVER;
        end
      end
      S_DIVIDE: begin
        dvd_d = dvd_q << 1;
        if (!dtrial[RegionW]) begin
          rem_d = dtrial[RegionW-1:0];
          quo_d = {quo_q[RegionW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[RegionW-2:0], dvd_q[RegionW-1]};
          quo_d = {quo_q[RegionW-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - 1'b1;
        if (dcnt_q == 5'd1) begin
          n_d = quo_d[RefillW-1:0];
          blk_d = WW'(cs_q);
          cs_d = RegionW'(WW'(cs_q) + bs_q * WW'(quo_d[RefillW-1:0]));
          k_d = RefillW'(1);
          state_d = S_LINK;
        end
      end
      S_LEFTOVER: begin
        if (left_w != '0 && WW'(cs_q >> GShift) < WW'(NGran)) begin
          head_we = 1'b1;
          head_wi = class_of(left_w);
          head_wd = LW'((cs_q >> GShift) + 1'b1);
          lk_we = 1'b1;
          lk_wa = GW'(cs_q >> GShift);
          lk_wd = head_q[class_of(left_w)];
        end
        cs_d = ce_q;
        state_d = S_BACKING;
      end
      S_BACKING: begin
        if (WW'(bn_q) + get_w <= BackLimW) begin
          cs_d = bn_q;
          ce_d = RegionW'(WW'(bn_q) + get_w);
          bn_d = RegionW'(WW'(bn_q) + get_w);
          ht_d = RegionW'(WW'(ht_q) + get_w);
          pass_d = pass_q + 1'b1;
          state_d = S_CARVE;
        end else begin
          sc_d = c_q;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (head_q[sc_q] != '0) begin
          g_d = GW'(head_q[sc_q] - 1'b1);
          state_d = S_SCAN_RD;
        end else if (sc_q == CW'(NClass - 1)) begin
          st_d = StOom; state_d = S_OUT;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end
      S_SCAN_RD: begin
        lk_ra = g_q;
        state_d = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        head_we = 1'b1; head_wi = sc_q; head_wd = lk_rd;
        cs_d = RegionW'(WW'(g_q) << GShift);
        ce_d = RegionW'((WW'(g_q) << GShift) + ((WW'(sc_q) + 1'b1) << GShift));
        pass_d = pass_q + 1'b1;
        state_d = S_CARVE;
      end
      S_LINK: begin
        if (k_q >= n_q) begin
          if (n_q > RefillW'(1)) begin
            head_we = 1'b1; head_wi = c_q;
            head_wd = LW'(((blk_q + bs_q) >> GShift) + 1'b1);
          end
          state_d = S_TAG;
        end else begin
          lk_wa = GW'((blk_q + bs_q * WW'(k_q)) >> GShift);
          lk_we = (((blk_q + bs_q * WW'(k_q)) >> GShift) < WW'(NGran));
          lk_wd = (k_q + 1'b1 < n_q) ?
            LW'(((blk_q + bs_q * WW'(k_q + 1'b1)) >> GShift) + 1'b1) : '0;
          k_d = k_q + 1'b1;
        end
      end
      S_TAG: begin
        tg_we = ((blk_q >> GShift) < WW'(NGran));
        ua_d = AddrW'(blk_q + HdrW);
        state_d = S_OUT;
      end
      S_FREE_RD: begin
        tg_ra = g_q;
        state_d = S_FREE_WAIT;
      end
      S_FREE_WAIT: begin
        s_d = WW'(tg_rd);
        state_d = S_FREE_PUSH;
      end
      S_FREE_PUSH: begin
        if (s_q != '0 && s_q <= LargestW) begin
          head_we = 1'b1;
          head_wi = class_of(s_q);
          head_wd = LW'(g_q) + 1'b1;
          lk_we = 1'b1; lk_wa = g_q; lk_wd = head_q[class_of(s_q)];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (rsp.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      refill_q <= RefillReset;
      cs_q <= '0; ce_q <= '0; bn_q <= '0; ht_q <= '0;
      for (int i = 0; i < NClass; i++) head_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) refill_q <= cfg_wdata_i;
      cs_q <= cs_d; ce_q <= ce_d; bn_q <= bn_d; ht_q <= ht_d;
      if (head_we) head_q[head_wi] <= head_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d; s_q <= s_d; c_q <= c_d; sc_q <= sc_d; bs_q <= bs_d;
    n_q <= n_d; pass_q <= pass_d; blk_q <= blk_d; k_q <= k_d;
    rem_q <= rem_d; quo_q <= quo_d; dcnt_q <= dcnt_d; dvd_q <= dvd_d;
    g_q <= g_d; st_q <= st_d; ua_q <= ua_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid) else $error("ready while result pending");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.user_addr))
    else $error("result dropped");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != StOk |-> rsp.user_addr == '0)
    else $error("error with address");
  a_carve_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_q <= ce_q || state_q == S_LEFTOVER) else $error("carve region inverted");
endmodule
`default_nettype wire

// ===== sim/alloc_checker.sv =====
`default_nettype none
module alloc_checker import sfa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RefillW-1:0] cfg_wdata_i,
  sfa_req_if                      req,
  sfa_rsp_if                      rsp,
  output int unsigned             mismatches_o,
  output int unsigned             outstanding_o
);
  localparam int unsigned NumClass  = LargestClassBytesDef / GranuleBytesDef;
  localparam int unsigned NumGran   = PoolBytesDef / GranuleBytesDef;
  localparam int unsigned PoolCap   = (PoolBytesDef < 65536) ? PoolBytesDef : 65536;
  localparam int unsigned HdrRound  =
    ((HeaderBytesDef + GranuleBytesDef - 1) / GranuleBytesDef) * GranuleBytesDef;
  localparam int unsigned BackLimit = PoolCap - HdrRound;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   user_addr;
  } grant_t;

  logic [13:0]        head_tbl [NumClass];
  logic [13:0]        link_tbl [NumGran];
  logic [7:0]         tag_tbl  [NumGran];
  logic [RegionW-1:0] carve_lo, carve_hi, backing_ptr, heap_bytes;
  logic [RefillW-1:0] refill_cnt;
  grant_t             expected_grants[$];

  assign outstanding_o = expected_grants.size();

  function automatic int unsigned class_for(int unsigned bytes);
    int unsigned c;
    c = (bytes + GranuleBytesDef - 1) / GranuleBytesDef;
    c = (c == 0) ? 0 : c - 1;
    return (c < NumClass) ? c : NumClass - 1;
  endfunction

  function automatic void push_free(int unsigned c, int unsigned addr);
    int unsigned g;
    g = addr / GranuleBytesDef;
    if (g >= NumGran || c >= NumClass) return;
    link_tbl[g] = head_tbl[c];
    head_tbl[c] = 14'(g + 1);
  endfunction

  function automatic int unsigned pop_free(int unsigned c);
    int unsigned h;
    h = head_tbl[c];
    if (h == 0 || h > NumGran) return 0;
    head_tbl[c] = link_tbl[h-1];
    return h;
  endfunction

  // carve n blocks of bs bytes; refills region from backing, then from a
  // block of an equal or larger class
  function automatic bit carve_blocks(int unsigned bs, inout int unsigned n,
                                      output int unsigned addr);
    int unsigned left, c, h;
    longint unsigned total, grab;
    bit found;
    addr = 0;
    for (int pass = 0; pass < 3; pass++) begin
      left  = carve_hi - carve_lo;
      total = longint'(bs) * n;
      found = 0;
      if (longint'(left) >= total) begin
        addr = carve_lo;
        carve_lo = RegionW'(carve_lo + total);
        return 1;
      end
      if (left >= bs) begin
        n = left / bs;
        addr = carve_lo;
        carve_lo = RegionW'(carve_lo + n * bs);
        return 1;
      end
      grab = 2 * total + ((longint'(heap_bytes >> 4) + GranuleBytesDef - 1)
                          / GranuleBytesDef) * GranuleBytesDef;
      if (left > 0) push_free(class_for(left), carve_lo);
      carve_lo = carve_hi;
      if (longint'(backing_ptr) + grab <= BackLimit) begin
        carve_lo    = backing_ptr;
        carve_hi    = RegionW'(backing_ptr + grab);
        backing_ptr = carve_hi;
        heap_bytes  = RegionW'(heap_bytes + grab);
        continue;
      end
      for (c = class_for(bs); c < NumClass; c++) begin
        h = pop_free(c);
        if (h != 0) begin
          carve_lo = RegionW'((h - 1) * GranuleBytesDef);
          carve_hi = RegionW'(carve_lo + (c + 1) * GranuleBytesDef);
          found = 1;
          break;
        end
      end
      if (!found) return 0;
    end
    return 0;
  endfunction

  function automatic grant_t predict_request(logic kind, int unsigned size,
                                             int unsigned baddr);
    grant_t      g;
    int unsigned s, c, h, blk, bs, n, gi, start, tag;
    g.status = StOk;
    g.user_addr = '0;
    if (kind == ReqAlloc) begin
      s = size + HeaderBytesDef;
      if (s > LargestClassBytesDef) begin
        g.status = StTooLarge;
        return g;
      end
      c = class_for(s);
      h = pop_free(c);
      if (h != 0) begin
        blk = (h - 1) * GranuleBytesDef;
      end else begin
        bs = (c + 1) * GranuleBytesDef;
        n  = (refill_cnt != 0) ? refill_cnt : 1;
        if (!carve_blocks(bs, n, blk)) begin
          g.status = StOom;
          return g;
        end
        if (n > 1) begin
          for (int unsigned k = 1; k < n; k++) begin
            gi = (blk + k * bs) / GranuleBytesDef;
            if (gi < NumGran)
              link_tbl[gi] = (k + 1 < n) ?
                14'((blk + (k + 1) * bs) / GranuleBytesDef + 1) : 14'd0;
          end
          head_tbl[c] = 14'((blk + bs) / GranuleBytesDef + 1);
        end
      end
      if (blk / GranuleBytesDef < NumGran) tag_tbl[blk / GranuleBytesDef] = 8'(s);
      g.user_addr = AddrW'(blk + HeaderBytesDef);
      return g;
    end
    if (baddr >= HeaderBytesDef) begin
      start = baddr - HeaderBytesDef;
      if (start < BackLimit) begin
        gi  = start / GranuleBytesDef;
        tag = (gi < NumGran) ? tag_tbl[gi] : 0;
        if (tag != 0 && tag <= LargestClassBytesDef)
          push_free(class_for(tag), gi * GranuleBytesDef);
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      foreach (head_tbl[i]) head_tbl[i] = '0;
      carve_lo     = '0;
      carve_hi     = '0;
      backing_ptr  = '0;
      heap_bytes   = '0;
      refill_cnt   = RefillReset;
      mismatches_o = 0;
      expected_grants.delete();
    end else begin
      if (cfg_we_i) refill_cnt = cfg_wdata_i;
      if (req.valid && req.ready)
        expected_grants.push_back(predict_request(req.req_type, req.req_size,
                                                  req.block_addr));
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $error("response with nothing expected: status %0d user_addr %0h",
                 rsp.status, rsp.user_addr);
          mismatches_o++;
        end else begin
          exp_g = expected_grants.pop_front();
          if (rsp.status !== exp_g.status) begin
            $error("status: expected %0d, got %0d", exp_g.status, rsp.status);
            mismatches_o++;
          end
          if (rsp.user_addr !== exp_g.user_addr) begin
            $error("user_addr: expected %0h, got %0h", exp_g.user_addr, rsp.user_addr);
            mismatches_o++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
// Top of the allocator bench. Drives allocate/free transactions on req,
// takes responses on rsp with random stalls, and steps refill_blocks through
// several values between phases. All prediction and compare lives in
// alloc_checker; this module only makes stimulus and reports the verdict.
module tb;
  import sfa_pkg::*;

  localparam int unsigned CycleLimit = 1000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RefillW-1:0] cfg_wdata_i;
  int unsigned        mismatches, outstanding;
  int unsigned        cycles = 0;
  int unsigned        n_alloc = 0, n_free = 0, n_rsp = 0, n_oom = 0, n_big = 0;
  logic [AddrW-1:0]   granted_addrs[$];   // user addresses handed out so far

  sfa_req_if req ();
  sfa_rsp_if rsp ();

  segregated_freelist_allocator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req.sink),
    .rsp         (rsp.source)
  );

  alloc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req           (req),
    .rsp           (rsp),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one transaction per call; valid stays high across back-to-back items
  task automatic send(logic kind, logic [ReqSizeW-1:0] size, logic [AddrW-1:0] baddr);
    int unsigned gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;   // bursts with no idling
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.req_size   <= size;
    req.block_addr <= baddr;
    forever begin
      @(negedge clk_i);
      if (req.ready) break;
    end
    @(posedge clk_i);
    if (kind == ReqAlloc) n_alloc++;
    else n_free++;
  endtask

  // let the block drain before touching refill_blocks
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_refill(logic [RefillW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // free a previously granted block, optionally with the address off by
  // up to 7 bytes inside its first granule
  task automatic free_granted();
    logic [AddrW-1:0] a;
    a = granted_addrs[$urandom_range(0, granted_addrs.size() - 1)];
    if ($urandom_range(0, 2) == 0) a = a + AddrW'($urandom_range(1, 7));
    send(ReqFree, ReqSizeW'($urandom), a);
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 || granted_addrs.size() == 0) begin
        // mostly small requests, spread over every size class
        send(ReqAlloc, ReqSizeW'($urandom_range(0, 120)), AddrW'($urandom));
      end else if (pick < 45) begin
        send(ReqAlloc, ReqSizeW'($urandom_range(121, 4095)), AddrW'($urandom));
      end else if (pick < 48) begin
        send(ReqFree, ReqSizeW'($urandom),
             AddrW'($urandom_range(0, HeaderBytesDef - 1)));
      end else begin
        free_granted();
      end
    end
  endtask

  // receiver: random stall per response, plus one long hold-off so the
  // block backs up and stops taking requests
  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (n_rsp == 150) stall = 600;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      forever begin
        @(negedge clk_i);
        if (rsp.valid) break;
      end
      if (rsp.status == StOk && rsp.user_addr != 0) granted_addrs.push_back(rsp.user_addr);
      if (rsp.status == StOom) n_oom++;
      if (rsp.status == StTooLarge) n_big++;
      @(posedge clk_i);
      n_rsp++;
    end
  end

  initial begin
    logic [AddrW-1:0] a;
    rst_ni      = 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    req.valid      <= 1'b0;
    req.req_type   <= ReqAlloc;
    req.req_size   <= '0;
    req.block_addr <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: size extremes, header-only, largest class, oversize
    send(ReqAlloc, 0, 0);
    send(ReqAlloc, 120, 0);
    send(ReqAlloc, 121, 0);
    send(ReqAlloc, 4095, 0);
    send(ReqAlloc, 1, 0);
    send(ReqAlloc, 56, 0);
    send(ReqAlloc, 120, 16'hffff);
    settle();
    // frees: exact, misaligned, double, below header
    a = granted_addrs[0];
    send(ReqFree, 0, a);
    send(ReqFree, 12'hfff, AddrW'(granted_addrs[1] + 7));
    send(ReqFree, 0, granted_addrs[1]);
    send(ReqFree, 0, 0);
    send(ReqFree, 0, AddrW'(HeaderBytesDef - 1));
    send(ReqAlloc, 0, 0);
    send(ReqAlloc, 120, 0);
    send(ReqAlloc, 120, 0);
    settle();

    // refill extremes: 1, 0 (acts as 1), 32, 63, then random
    write_refill(6'd1);
    send(ReqAlloc, 64, 0);
    send(ReqAlloc, 64, 0);
    random_phase(150);
    settle();
    write_refill(6'd0);
    random_phase(150);
    settle();
    write_refill(6'd32);
    random_phase(250);
    settle();
    write_refill(6'd63);
    random_phase(250);
    settle();
    write_refill(6'($urandom_range(2, 31)));
    random_phase(330);
    settle();

    $display("covered %0d allocates, %0d frees, %0d responses", n_alloc, n_free, n_rsp);
    $display("out-of-memory answers %0d, oversize answers %0d", n_oom, n_big);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
